[src/abts_pkg.sv]
// ----------------------------------------------------------------------------
// abts_pkg
// Shared types, codes and decode helpers for the branch trampoline scanner.
// ----------------------------------------------------------------------------
package abts_pkg;

    localparam int ABTS_MAX_WINDOW_WORDS = 64;
    localparam int ABTS_LA_DEPTH         = 4;
    localparam int ABTS_CAP_W            = 7;
    localparam int ABTS_CAP_RESET        = 64;

    localparam logic [31:0] M_BL   = 32'hFC00_0000;
    localparam logic [31:0] V_BL   = 32'h9400_0000;
    localparam logic [31:0] M_BRX  = 32'hFFFF_FC1F;
    localparam logic [31:0] V_BLR  = 32'hD63F_0000;
    localparam logic [31:0] V_BR   = 32'hD61F_0000;
    localparam logic [31:0] M_ADRP = 32'h9F00_0000;
    localparam logic [31:0] V_ADRP = 32'h9000_0000;
    localparam logic [31:0] M_ADDI = 32'hFFC0_0000;
    localparam logic [31:0] V_ADDI = 32'h9100_0000;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_BL   = 3'd1,
        KIND_BLR  = 3'd2,
        KIND_BR   = 3'd3,
        KIND_ADRP = 3'd4
    } t_kind;

    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } t_state;

    typedef logic [ABTS_LA_DEPTH-1:0][31:0] t_word_arr;
    typedef logic [ABTS_LA_DEPTH-1:0][63:0] t_addr_arr;

    typedef struct packed {
        logic        hit;
        t_kind       kind;
        logic [31:0] word;
        logic [63:0] target;
        logic [4:0]  reg_num;
    } t_exam_res;

    typedef struct packed {
        logic accept;
        logic drain_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_zero;
        logic held;
        logic out_busy;
    } t_dp_stat;

    function automatic logic is_brx_on(input logic [31:0] w, input logic [4:0] rd);
        return (((w & M_BRX) == V_BR) || ((w & M_BRX) == V_BLR)) && (w[9:5] == rd);
    endfunction

    function automatic logic is_addi_to(input logic [31:0] w, input logic [4:0] rd);
        return ((w & M_ADDI) == V_ADDI) && (w[4:0] == rd) && (w[9:5] == rd);
    endfunction

endpackage

[src/abts_exam.sv]
// ----------------------------------------------------------------------------
// abts_exam
// Decodes the oldest buffered word against its lookahead and resolves target.
// ----------------------------------------------------------------------------
module abts_exam (
    input  abts_pkg::t_word_arr i_words,
    input  logic [63:0]         i_pc,
    input  logic [2:0]          i_count,
    output abts_pkg::t_exam_res o_res
);
    import abts_pkg::*;

    logic [31:0] w0;
    logic [4:0]  rd;
    logic [63:0] bl_target;
    logic [20:0] imm21;
    logic [51:0] page;
    logic [63:0] base;

    assign w0        = i_words[0];
    assign rd        = w0[4:0];
    assign bl_target = i_pc + {{36{w0[25]}}, w0[25:0], 2'b00};
    assign imm21     = {w0[23:5], w0[30:29]};
    assign page      = i_pc[63:12] + {{31{imm21[20]}}, imm21};
    assign base      = {page, 12'h000};

    always_comb begin
        o_res = '0;
        if ((w0 & M_BL) == V_BL) begin
            o_res = '{hit: 1'b1, kind: KIND_BL, word: w0, target: bl_target, reg_num: 5'd0};
        end else if ((w0 & M_BRX) == V_BLR) begin
            o_res = '{hit: 1'b1, kind: KIND_BLR, word: w0, target: 64'd0, reg_num: w0[9:5]};
        end else if ((w0 & M_BRX) == V_BR) begin
            o_res = '{hit: 1'b1, kind: KIND_BR, word: w0, target: 64'd0, reg_num: w0[9:5]};
        end else if ((w0 & M_ADRP) == V_ADRP) begin
            o_res.kind    = KIND_ADRP;
            o_res.word    = w0;
            o_res.reg_num = rd;
            // BR/BLR on rd one or two words on, or just after an ADD-imm on rd;
            // the page base has zero low bits, so imm12 just fills them in
            if (i_count > 3'd2 && is_addi_to(i_words[1], rd)
                && is_brx_on(i_words[2], rd)) begin
                o_res.hit    = 1'b1;
                o_res.target = {page, i_words[1][21:10]};
            end else if (i_count > 3'd1 && is_brx_on(i_words[1], rd)) begin
                o_res.hit    = 1'b1;
                o_res.target = base;
            end else if (i_count > 3'd3 && is_addi_to(i_words[2], rd)
                         && is_brx_on(i_words[3], rd)) begin
                o_res.hit    = 1'b1;
                o_res.target = {page, i_words[2][21:10]};
            end else if (i_count > 3'd2 && is_brx_on(i_words[2], rd)) begin
                o_res.hit    = 1'b1;
                o_res.target = base;
            end else begin
                o_res = '0;
            end
        end
    end

endmodule

[src/abts_dp.sv]
// ----------------------------------------------------------------------------
// abts_dp
// Lookahead buffer, window counters, held match and output register.
// ----------------------------------------------------------------------------
module abts_dp #(
    parameter int MAX_WINDOW_WORDS = abts_pkg::ABTS_MAX_WINDOW_WORDS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  abts_pkg::t_dp_cmd             i_cmd,
    output abts_pkg::t_dp_stat            o_stat,
    input  logic                          i_cfg_we,
    input  logic [abts_pkg::ABTS_CAP_W-1:0] i_cfg_data,
    input  logic [31:0]                   i_instr_word,
    input  logic [63:0]                   i_instr_addr,
    input  logic                          i_last_word,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [2:0]                    o_match_kind,
    output logic [7:0]                    o_match_offset,
    output logic [31:0]                   o_match_word,
    output logic [63:0]                   o_target_addr,
    output logic [4:0]                    o_target_reg
);
    import abts_pkg::*;

    localparam int TW = $clog2(MAX_WINDOW_WORDS + 1);

    logic [ABTS_CAP_W-1:0] r_cap;
    logic [TW-1:0]         r_taken, n_taken, cap_eff;
    logic [2:0]            r_fill, n_fill, fill_v;
    logic [5:0]            r_head, n_head;
    logic                  r_held, n_held;
    t_word_arr             r_word, n_word, v_word;
    t_addr_arr             r_addr, n_addr, v_addr;
    t_exam_res             r_hres, n_hres, exam;
    logic [7:0]            r_hoff, n_hoff;
    logic                  r_out_valid;
    logic [2:0]            r_o_kind;
    logic [7:0]            r_o_off;
    logic [31:0]           r_o_word;
    logic [63:0]           r_o_target;
    logic [4:0]            r_o_reg;
    logic                  push, step, do_exam;

    assign cap_eff = (r_cap == '0 || int'(r_cap) > MAX_WINDOW_WORDS)
                   ? TW'(MAX_WINDOW_WORDS) : TW'(r_cap);
    assign push    = i_cmd.accept && (r_taken < cap_eff) && (r_fill < 3'd4);
    assign fill_v  = r_fill + {2'b00, push};
    // a full buffer on a non-final word, or one drain step, retires slot 0
    assign step    = (i_cmd.accept && !i_last_word && fill_v == 3'd4) || i_cmd.drain_step;
    assign do_exam = step && !r_held;

    always_comb begin
        v_word = r_word;
        v_addr = r_addr;
        if (push) begin
            v_word[r_fill[1:0]] = i_instr_word;
            v_addr[r_fill[1:0]] = i_instr_addr;
        end
    end

    abts_exam u_exam (
        .i_words (v_word),
        .i_pc    (v_addr[0]),
        .i_count (fill_v),
        .o_res   (exam)
    );

    always_comb begin
        n_word  = v_word;
        n_addr  = v_addr;
        n_fill  = fill_v;
        n_head  = r_head;
        n_taken = r_taken + TW'(push);
        n_held  = r_held;
        n_hres  = r_hres;
        n_hoff  = r_hoff;
        if (do_exam && exam.hit) begin
            n_held = 1'b1;
            n_hres = exam;
            n_hoff = {r_head, 2'b00};
        end
        if (step) begin
            for (int i = 0; i < ABTS_LA_DEPTH - 1; i++) begin
                n_word[i] = v_word[i+1];
                n_addr[i] = v_addr[i+1];
            end
            n_fill = fill_v - 3'd1;
            n_head = r_head + 6'd1;
        end
        if (i_cmd.load_out) begin
            n_fill  = '0;
            n_head  = '0;
            n_taken = '0;
            n_held  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= ABTS_CAP_W'(ABTS_CAP_RESET);
            r_fill      <= '0;
            r_head      <= '0;
            r_taken     <= '0;
            r_held      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            r_fill  <= n_fill;
            r_head  <= n_head;
            r_taken <= n_taken;
            r_held  <= n_held;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_addr <= n_addr;
        r_hres <= n_hres;
        r_hoff <= n_hoff;
        if (i_cmd.load_out) begin
            r_o_kind   <= r_held ? r_hres.kind    : KIND_NONE;
            r_o_off    <= r_held ? r_hoff         : 8'd0;
            r_o_word   <= r_held ? r_hres.word    : 32'd0;
            r_o_target <= r_held ? r_hres.target  : 64'd0;
            r_o_reg    <= r_held ? r_hres.reg_num : 5'd0;
        end
    end

    assign o_stat.fill_zero = (r_fill == 3'd0);
    assign o_stat.held      = r_held;
    assign o_stat.out_busy  = r_out_valid;

    assign o_out_valid    = r_out_valid;
    assign o_match_kind   = r_o_kind;
    assign o_match_offset = r_o_off;
    assign o_match_word   = r_o_word;
    assign o_target_addr  = r_o_target;
    assign o_target_reg   = r_o_reg;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 3'd4)
        else $error("lookahead fill above depth");

    a_taken_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_taken) <= MAX_WINDOW_WORDS)
        else $error("words taken above window cap");

    a_clear_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> (r_fill == 3'd0 && !r_held && r_taken == '0 && r_out_valid))
        else $error("window not cleared after result load");

endmodule

[src/abts_ctrl.sv]
// ----------------------------------------------------------------------------
// abts_ctrl
// Window sequencer: accept words, drain the lookahead, hand off the result.
// ----------------------------------------------------------------------------
module abts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_last_word,
    input  logic               i_out_ready,
    input  abts_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output abts_pkg::t_dp_cmd  o_cmd
);
    import abts_pkg::*;

    t_state r_state, n_state;
    logic   drain_done, out_free;

    assign drain_done = i_stat.fill_zero || i_stat.held;
    assign out_free   = !i_stat.out_busy || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_last_word) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_done && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_DRAIN: begin
                o_cmd.drain_step = !drain_done;
                o_cmd.load_out   = drain_done && out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_step_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.drain_step |-> (!i_stat.fill_zero && !i_stat.held))
        else $error("drain step with nothing to examine");

    a_load_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!i_stat.out_busy || i_out_ready))
        else $error("result loaded over an untaken result");

    a_last_enters_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_last_word) |=> (r_state == ST_DRAIN))
        else $error("final word did not start the drain");

endmodule

[src/aarch64_branch_trampoline_scanner.sv]
// ----------------------------------------------------------------------------
// aarch64_branch_trampoline_scanner
// Finds the first BL, BLR, BR or ADRP-fed indirect branch in a word window.
// ----------------------------------------------------------------------------
// Words that do not end a window are taken one per cycle; each costs one pass
// through the examine unit (mask compares, one 64-bit and one 52-bit add) as
// the oldest word leaves the four-word lookahead buffer. After the final word
// of a window is taken, the block drains the lookahead, one buffered word per
// cycle through the same examine unit, stopping early on a match, and then
// loads the result register once that register is free. The input channel is
// closed from the final word until the result is loaded. The result register
// lets the next window start while the previous result still waits to be
// taken; there is no clearing pass after reset.
module aarch64_branch_trampoline_scanner #(
    parameter int MAX_WINDOW_WORDS = abts_pkg::ABTS_MAX_WINDOW_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [abts_pkg::ABTS_CAP_W-1:0] i_cfg_max_scan_words,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_instr_word,
    input  logic [63:0] i_instr_addr,
    input  logic        i_last_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_match_kind,
    output logic [7:0]  o_match_offset,
    output logic [31:0] o_match_word,
    output logic [63:0] o_target_addr,
    output logic [4:0]  o_target_reg
);
    import abts_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    abts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_word (i_last_word),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    abts_dp #(
        .MAX_WINDOW_WORDS (MAX_WINDOW_WORDS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_data     (i_cfg_max_scan_words),
        .i_instr_word   (i_instr_word),
        .i_instr_addr   (i_instr_addr),
        .i_last_word    (i_last_word),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_match_kind   (o_match_kind),
        .o_match_offset (o_match_offset),
        .o_match_word   (o_match_word),
        .o_target_addr  (o_target_addr),
        .o_target_reg   (o_target_reg)
    );

endmodule
